// ===== hw/rtl/fdsu_pkg.sv =====
package fdsu_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned OpW           = 5;
  localparam int unsigned StatW         = 2;
  localparam int unsigned DepthOutW     = 7;
  localparam int unsigned StackDepthDef = 64;

  // operation codes
  localparam logic [OpW-1:0] OP_PUSH   = 5'd0;
  localparam logic [OpW-1:0] OP_PRINT  = 5'd1;
  localparam logic [OpW-1:0] OP_PEEK   = 5'd2;
  localparam logic [OpW-1:0] OP_ADD    = 5'd3;
  localparam logic [OpW-1:0] OP_SUB    = 5'd4;
  localparam logic [OpW-1:0] OP_MUL    = 5'd5;
  localparam logic [OpW-1:0] OP_DIV    = 5'd6;
  localparam logic [OpW-1:0] OP_NEG    = 5'd7;
  localparam logic [OpW-1:0] OP_ABS    = 5'd8;
  localparam logic [OpW-1:0] OP_MOD    = 5'd9;
  localparam logic [OpW-1:0] OP_MAX    = 5'd10;
  localparam logic [OpW-1:0] OP_MIN    = 5'd11;
  localparam logic [OpW-1:0] OP_DUP    = 5'd12;
  localparam logic [OpW-1:0] OP_NOT    = 5'd13;
  localparam logic [OpW-1:0] OP_EQ     = 5'd14;
  localparam logic [OpW-1:0] OP_SWAP   = 5'd15;
  localparam logic [OpW-1:0] OP_DROP   = 5'd16;
  localparam logic [OpW-1:0] OP_OVER   = 5'd17;
  localparam logic [OpW-1:0] OP_ROT    = 5'd18;
  localparam logic [OpW-1:0] OP_PICK   = 5'd19;
  localparam logic [OpW-1:0] OP_ROLL   = 5'd20;
  localparam logic [OpW-1:0] OP_NOP    = 5'd21;
  localparam logic [OpW-1:0] OP_DEPTH  = 5'd22;
  localparam logic [OpW-1:0] OP_CLEAR  = 5'd23;

  // status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_UNDER = 2'd1;
  localparam logic [StatW-1:0] ST_OVER  = 2'd2;
  localparam logic [StatW-1:0] ST_DIVZ  = 2'd3;

  // entries an operation needs before it runs
  function automatic logic [1:0] op_need(logic [OpW-1:0] op);
    logic [1:0] n;
    case (op)
      OP_PRINT, OP_PEEK, OP_NEG, OP_ABS, OP_DUP, OP_NOT, OP_DROP,
      OP_PICK, OP_ROLL: n = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_MAX, OP_MIN, OP_EQ,
      OP_SWAP, OP_OVER: n = 2'd2;
      OP_ROT: n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // operations that add one entry
  function automatic logic op_grows(logic [OpW-1:0] op);
    logic g;
    case (op)
      OP_PUSH, OP_DUP, OP_OVER, OP_DEPTH: g = 1'b1;
      default: g = 1'b0;
    endcase
    return g;
  endfunction

endpackage

// ===== hw/rtl/forth_data_stack_unit.sv =====
// channel   | dir | tdata (low bit up)                               | tuser
// s_axis    | in  | operation[4:0], literal_value[36:5], pad to 40  | -
// m_axis    | out | print_value[31:0], status[33:32],               | print_valid
//           |     | entry_count[40:34], pad to 48                    |
//
// one item at a time; how long each op runs is set by its stack ram reads and writes
// div and mod also wait on the radix-2 divider that they share
// roll moves each entry with a read then a write of the stack ram
// reset clears the pointer and control; stack entries hold nothing until pushed
// a held result stalls only the end of the next item, not its acceptance
module forth_data_stack_unit #(
  parameter int unsigned NumEntries = fdsu_pkg::StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // operation, literal_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // print_value, status, entry_count
  output logic        m_axis_tuser   // print_valid
);

  localparam int unsigned W     = fdsu_pkg::DataW;
  localparam int unsigned SpW   = $clog2(NumEntries + 1);
  localparam int unsigned AddrW = $clog2(NumEntries);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RX   = 4'd1;
  localparam logic [3:0] S_CX   = 4'd2;
  localparam logic [3:0] S_CY   = 4'd3;
  localparam logic [3:0] S_CZ   = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_PCAP = 4'd6;
  localparam logic [3:0] S_RLRD = 4'd7;
  localparam logic [3:0] S_RLWR = 4'd8;
  localparam logic [3:0] S_DIVW = 4'd9;
  localparam logic [3:0] S_WR   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]                   state_q;
  logic [SpW-1:0]               sp_q;
  logic [SpW-1:0]               nsp_q;
  logic [fdsu_pkg::OpW-1:0]     op_q;
  logic [W-1:0]                 lit_q;
  logic [W-1:0]                 x_q, y_q, z_q, r_q;
  logic [fdsu_pkg::StatW-1:0]   st_q;
  logic                         pvalid_q;
  logic [W-1:0]                 pv_q;
  logic [AddrW-1:0]             k_q;
  logic [AddrW-1:0]             waddr_q [3];
  logic [W-1:0]                 wdata_q [3];
  logic [1:0]                   wnum_q, wi_q;

  logic                         out_valid_q, out_pvalid_q;
  logic [W-1:0]                 out_pv_q;
  logic [fdsu_pkg::StatW-1:0]   out_st_q;
  logic [fdsu_pkg::DepthOutW-1:0] out_depth_q;

  logic [fdsu_pkg::OpW-1:0]     in_op;
  logic [W-1:0]                 in_lit;
  logic [1:0]                   need, need_op;
  logic [AddrW-1:0]             a_top, a1, a2, a3, base;
  logic                         pk_ok;
  logic [W-1:0]                 alu_res, mag_x, mag_y, div_res;
  logic                         div_start, div_done;
  logic [W-1:0]                 div_quot, div_rem;
  logic                         ram_we, ram_re;
  logic [AddrW-1:0]             ram_waddr, ram_raddr;
  logic [W-1:0]                 ram_wdata, ram_rdata;
  logic                         in_beat;
  logic                         out_load;

  assign in_op  = (s_axis_tdata[4:0] > fdsu_pkg::OP_CLEAR) ? fdsu_pkg::OP_NOP
                                                           : s_axis_tdata[4:0];
  assign in_lit  = s_axis_tdata[36:5];
  assign need    = fdsu_pkg::op_need(in_op);
  assign need_op = fdsu_pkg::op_need(op_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // stack addresses
  assign a_top = AddrW'(sp_q);
  assign a1    = AddrW'(sp_q - SpW'(1));
  assign a2    = AddrW'(sp_q - SpW'(2));
  assign a3    = AddrW'(sp_q - SpW'(3));
  assign pk_ok = !x_q[W-1] && (sp_q >= SpW'(2)) && (x_q <= W'(sp_q - SpW'(2)));
  assign base  = AddrW'(sp_q - SpW'(2) - SpW'(x_q));

  // combinational alu, result registered in the write buffer
  always_comb begin
    case (op_q)
      fdsu_pkg::OP_ADD: alu_res = y_q + x_q;
      fdsu_pkg::OP_SUB: alu_res = y_q - x_q;
      fdsu_pkg::OP_MUL: alu_res = W'(y_q * x_q);
      fdsu_pkg::OP_NEG: alu_res = '0 - x_q;
      fdsu_pkg::OP_ABS: alu_res = mag_x;
      fdsu_pkg::OP_MAX: alu_res = ($signed(x_q) > $signed(y_q)) ? x_q : y_q;
      fdsu_pkg::OP_MIN: alu_res = ($signed(y_q) > $signed(x_q)) ? x_q : y_q;
      fdsu_pkg::OP_NOT: alu_res = W'(x_q == '0);
      fdsu_pkg::OP_EQ:  alu_res = W'(x_q == y_q);
      default:          alu_res = x_q;
    endcase
  end

  // divider operands and signed fix-up
  assign mag_x     = x_q[W-1] ? ('0 - x_q) : x_q;
  assign mag_y     = y_q[W-1] ? ('0 - y_q) : y_q;
  assign div_start = (state_q == S_EXEC) && (x_q != '0) &&
                     ((op_q == fdsu_pkg::OP_DIV) || (op_q == fdsu_pkg::OP_MOD));
  always_comb begin
    if (op_q == fdsu_pkg::OP_DIV) begin
      div_res = (x_q[W-1] ^ y_q[W-1]) ? ('0 - div_quot) : div_quot;
    end else begin
      div_res = y_q[W-1] ? ('0 - div_rem) : div_rem;
    end
  end

  fdsu_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_y),
    .divisor_i  (mag_x),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ram port control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = a1;
    ram_we    = 1'b0;
    ram_waddr = waddr_q[wi_q];
    ram_wdata = wdata_q[wi_q];
    case (state_q)
      S_RX: ram_re = 1'b1;
      S_CX: begin
        ram_re    = (need_op >= 2'd2);
        ram_raddr = a2;
      end
      S_CY: begin
        ram_re    = (need_op == 2'd3);
        ram_raddr = a3;
      end
      S_EXEC: begin
        ram_re    = pk_ok && ((op_q == fdsu_pkg::OP_PICK) || (op_q == fdsu_pkg::OP_ROLL));
        ram_raddr = base;
      end
      S_RLRD: begin
        ram_re    = 1'b1;
        ram_raddr = AddrW'(k_q + 1'b1);
      end
      S_RLWR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q;
        ram_wdata = ram_rdata;
      end
      S_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  fdsu_stack_ram #(
    .Depth (NumEntries),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            op_q     <= in_op;
            lit_q    <= in_lit;
            nsp_q    <= sp_q;
            pvalid_q <= 1'b0;
            pv_q     <= '0;
            wi_q     <= '0;
            wnum_q   <= '0;
            if (sp_q < SpW'(need)) begin
              st_q    <= fdsu_pkg::ST_UNDER;
              state_q <= S_DONE;
            end else if (fdsu_pkg::op_grows(in_op) && sp_q >= SpW'(NumEntries)) begin
              st_q    <= fdsu_pkg::ST_OVER;
              state_q <= S_DONE;
            end else begin
              st_q    <= fdsu_pkg::ST_OK;
              state_q <= (need == 2'd0) ? S_EXEC : S_RX;
            end
          end
        end
        S_RX: state_q <= S_CX;
        S_CX: begin
          x_q     <= ram_rdata;
          state_q <= (need_op >= 2'd2) ? S_CY : S_EXEC;
        end
        S_CY: begin
          y_q     <= ram_rdata;
          state_q <= (need_op == 2'd3) ? S_CZ : S_EXEC;
        end
        S_CZ: begin
          z_q     <= ram_rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (op_q)
            fdsu_pkg::OP_PUSH, fdsu_pkg::OP_DUP, fdsu_pkg::OP_OVER,
            fdsu_pkg::OP_DEPTH: begin
              waddr_q[0] <= a_top;
              wdata_q[0] <= (op_q == fdsu_pkg::OP_PUSH)  ? lit_q :
                            (op_q == fdsu_pkg::OP_DUP)   ? x_q :
                            (op_q == fdsu_pkg::OP_OVER)  ? y_q : W'(sp_q);
              wnum_q     <= 2'd1;
              nsp_q      <= sp_q + 1'b1;
              state_q    <= S_WR;
            end
            fdsu_pkg::OP_PRINT, fdsu_pkg::OP_PEEK: begin
              pvalid_q <= 1'b1;
              pv_q     <= x_q;
              state_q  <= S_DONE;
              if (op_q == fdsu_pkg::OP_PRINT) begin
                nsp_q <= sp_q - 1'b1;
              end
            end
            fdsu_pkg::OP_ADD, fdsu_pkg::OP_SUB, fdsu_pkg::OP_MUL, fdsu_pkg::OP_MAX,
            fdsu_pkg::OP_MIN, fdsu_pkg::OP_EQ: begin
              waddr_q[0] <= a2;
              wdata_q[0] <= alu_res;
              wnum_q     <= 2'd1;
              nsp_q      <= sp_q - 1'b1;
              state_q    <= S_WR;
            end
            fdsu_pkg::OP_NEG, fdsu_pkg::OP_ABS, fdsu_pkg::OP_NOT: begin
              waddr_q[0] <= a1;
              wdata_q[0] <= alu_res;
              wnum_q     <= 2'd1;
              state_q    <= S_WR;
            end
            fdsu_pkg::OP_DIV, fdsu_pkg::OP_MOD: begin
              if (x_q == '0) begin
                st_q    <= fdsu_pkg::ST_DIVZ;
                state_q <= S_DONE;
              end else begin
                state_q <= S_DIVW;
              end
            end
            fdsu_pkg::OP_SWAP: begin
              waddr_q[0] <= a1;
              wdata_q[0] <= y_q;
              waddr_q[1] <= a2;
              wdata_q[1] <= x_q;
              wnum_q     <= 2'd2;
              state_q    <= S_WR;
            end
            fdsu_pkg::OP_ROT: begin
              waddr_q[0] <= a3;
              wdata_q[0] <= y_q;
              waddr_q[1] <= a2;
              wdata_q[1] <= x_q;
              waddr_q[2] <= a1;
              wdata_q[2] <= z_q;
              wnum_q     <= 2'd3;
              state_q    <= S_WR;
            end
            fdsu_pkg::OP_DROP: begin
              nsp_q   <= sp_q - 1'b1;
              state_q <= S_DONE;
            end
            fdsu_pkg::OP_PICK, fdsu_pkg::OP_ROLL: begin
              if (pk_ok) begin
                k_q     <= base;
                state_q <= S_PCAP;
              end else begin
                st_q    <= fdsu_pkg::ST_UNDER;
                state_q <= S_DONE;
              end
            end
            fdsu_pkg::OP_CLEAR: begin
              nsp_q   <= '0;
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_DIVW: begin
          if (div_done) begin
            waddr_q[0] <= a2;
            wdata_q[0] <= div_res;
            wnum_q     <= 2'd1;
            nsp_q      <= sp_q - 1'b1;
            state_q    <= S_WR;
          end
        end
        S_PCAP: begin
          r_q    <= ram_rdata;
          wnum_q <= 2'd1;
          if (op_q == fdsu_pkg::OP_PICK) begin
            waddr_q[0] <= a1;
            wdata_q[0] <= ram_rdata;
            state_q    <= S_WR;
          end else if (SpW'(k_q) + SpW'(2) < sp_q) begin
            state_q <= S_RLRD;
          end else begin
            waddr_q[0] <= a2;
            wdata_q[0] <= ram_rdata;
            nsp_q      <= sp_q - 1'b1;
            state_q    <= S_WR;
          end
        end
        S_RLRD: state_q <= S_RLWR;
        S_RLWR: begin
          k_q <= AddrW'(k_q + 1'b1);
          if (SpW'(k_q) + SpW'(3) < sp_q) begin
            state_q <= S_RLRD;
          end else begin
            waddr_q[0] <= a2;
            wdata_q[0] <= r_q;
            nsp_q      <= sp_q - 1'b1;
            state_q    <= S_WR;
          end
        end
        S_WR: begin
          wi_q <= wi_q + 1'b1;
          if (wi_q == wnum_q - 1'b1) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_pvalid_q <= pvalid_q;
            out_pv_q     <= pv_q;
            out_st_q     <= st_q;
            out_depth_q  <= fdsu_pkg::DepthOutW'(nsp_q);
            sp_q         <= nsp_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_pvalid_q;
  assign m_axis_tdata  = {7'd0, out_depth_q, out_st_q, out_pv_q};

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(NumEntries))
    else $error("stack pointer beyond depth");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("ram read and write in one cycle");

  a_print_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pvalid_q) |-> (out_st_q == fdsu_pkg::ST_OK))
    else $error("printed value with error status");
`endif

endmodule

// ===== hw/rtl/fdsu_stack_ram.sv =====
module fdsu_stack_ram #(
  parameter int unsigned Depth = fdsu_pkg::StackDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [fdsu_pkg::DataW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [fdsu_pkg::DataW-1:0] rdata_o
);

  logic [fdsu_pkg::DataW-1:0] mem_q [Depth];
  logic [fdsu_pkg::DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fdsu_divider.sv =====
module fdsu_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fdsu_pkg::DataW-1:0] dividend_i,
  input  logic [fdsu_pkg::DataW-1:0] divisor_i,
  output logic                       done_o,
  output logic [fdsu_pkg::DataW-1:0] quot_o,
  output logic [fdsu_pkg::DataW-1:0] rem_o
);

  localparam int unsigned W    = fdsu_pkg::DataW;
  localparam int unsigned CntW = $clog2(W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    dvs_q;
  logic [W:0]      trial;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        if (!trial[W]) begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[W-2:0], quo_q[W-1]};
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
